>>> hdl/gept_pkg.sv
package gept_pkg;

   localparam int unsigned MM_W     = 12;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned FRAC_W   = 8;
   localparam int unsigned FILT_W   = MM_W + FRAC_W;
   localparam int unsigned PSTATE_W = 2;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = RATE_W;
   localparam int unsigned REQ_DW   = 16;
   localparam int unsigned RSP_DW   = 24;

   // register indexes on the csr port
   typedef enum logic [CSR_AW-1:0] {
      CSR_GATE_LOW     = 3'd0,
      CSR_GATE_HIGH    = 3'd1,
      CSR_RATE         = 3'd2,
      CSR_FREE_ABOVE   = 3'd3,
      CSR_NEAR_BELOW   = 3'd4,
      CSR_CONTACT_LOW  = 3'd5,
      CSR_CONTACT_HIGH = 3'd6
   } csr_index_type;

   localparam logic [MM_W-1:0]   GATE_LOW_RST     = 12'd10;
   localparam logic [MM_W-1:0]   GATE_HIGH_RST    = 12'd1900;
   localparam logic [RATE_W-1:0] RATE_RST         = 16'd2621;
   localparam logic [MM_W-1:0]   FREE_ABOVE_RST   = 12'd500;
   localparam logic [MM_W-1:0]   NEAR_BELOW_RST   = 12'd230;
   localparam logic [MM_W-1:0]   CONTACT_LOW_RST  = 12'd240;
   localparam logic [MM_W-1:0]   CONTACT_HIGH_RST = 12'd260;

   typedef struct packed {
      logic [MM_W-1:0]   gate_low_mm;
      logic [MM_W-1:0]   gate_high_mm;
      logic [RATE_W-1:0] smoothing_rate;
      logic [MM_W-1:0]   free_above_mm;
      logic [MM_W-1:0]   near_below_mm;
      logic [MM_W-1:0]   contact_low_mm;
      logic [MM_W-1:0]   contact_high_mm;
   } cfg_type;

   typedef enum logic [3:0] {
      PROX_CLEAR    = 4'b0001,
      PROX_DETECTED = 4'b0010,
      PROX_NEARBY   = 4'b0100,
      PROX_CONTACT  = 4'b1000
   } prox_state_type;

   localparam logic [PSTATE_W-1:0] CODE_CLEAR    = 2'd0;
   localparam logic [PSTATE_W-1:0] CODE_DETECTED = 2'd1;
   localparam logic [PSTATE_W-1:0] CODE_NEARBY   = 2'd2;
   localparam logic [PSTATE_W-1:0] CODE_CONTACT  = 2'd3;

   typedef struct packed {
      logic [FILT_W-1:0]   filter;
      prox_state_type      state;
      logic                accept;
   } update_type;

   function automatic logic [PSTATE_W-1:0] state_code(prox_state_type st);
      logic [PSTATE_W-1:0] code;
      unique case (st)
         PROX_CLEAR:    code = CODE_CLEAR;
         PROX_DETECTED: code = CODE_DETECTED;
         PROX_NEARBY:   code = CODE_NEARBY;
         PROX_CONTACT:  code = CODE_CONTACT;
         default:       code = CODE_CLEAR;
      endcase
      return code;
   endfunction

endpackage

>>> hdl/gept_update.sv
module gept_update (
   input  logic [gept_pkg::MM_W-1:0]   sample_mm,
   input  logic [gept_pkg::FILT_W-1:0] filter_value,
   input  gept_pkg::prox_state_type    state,
   input  gept_pkg::cfg_type           cfg,
   output gept_pkg::update_type        upd
);
   import gept_pkg::*;

   localparam int unsigned DIFF_W = FILT_W + 1;
   localparam int unsigned PROD_W = DIFF_W + RATE_W + 1;

   logic                     accept;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] step;
   logic signed [DIFF_W:0]   sum;
   logic [FILT_W-1:0]        v;
   logic [FILT_W-1:0]        free_thr;
   logic [FILT_W-1:0]        near_thr;
   logic [FILT_W-1:0]        clo_thr;
   logic [FILT_W-1:0]        chi_thr;
   logic                     free_space;
   logic                     in_contact;
   prox_state_type           next_state;

   always_comb begin
      accept = (sample_mm >= cfg.gate_low_mm) && (sample_mm <= cfg.gate_high_mm);
      diff   = $signed({1'b0, sample_mm, {FRAC_W{1'b0}}}) - $signed({1'b0, filter_value});
      prod   = $signed({1'b0, cfg.smoothing_rate}) * diff;
      // arithmetic shift floors toward minus infinity
      step   = prod >>> RATE_W;
      sum    = $signed({2'b00, filter_value}) + $signed(step[DIFF_W:0]);
      v      = accept ? sum[FILT_W-1:0] : filter_value;
   end

   always_comb begin
      free_thr   = {cfg.free_above_mm, {FRAC_W{1'b0}}};
      near_thr   = {cfg.near_below_mm, {FRAC_W{1'b0}}};
      clo_thr    = {cfg.contact_low_mm, {FRAC_W{1'b0}}};
      chi_thr    = {cfg.contact_high_mm, {FRAC_W{1'b0}}};
      free_space = v > free_thr;
      in_contact = (v > clo_thr) && (v < chi_thr);
      unique case (state)
         PROX_CLEAR:    next_state = free_space ? PROX_CLEAR : PROX_DETECTED;
         PROX_DETECTED: begin
            priority if (free_space)    next_state = PROX_CLEAR;
            else if (v < near_thr)      next_state = PROX_NEARBY;
            else                        next_state = PROX_DETECTED;
         end
         PROX_NEARBY: begin
            priority if (free_space)    next_state = PROX_CLEAR;
            else if (in_contact)        next_state = PROX_CONTACT;
            else                        next_state = PROX_NEARBY;
         end
         PROX_CONTACT:  next_state = in_contact ? PROX_CONTACT : PROX_CLEAR;
         default:       next_state = PROX_CLEAR;
      endcase
   end

   assign upd.filter = v;
   assign upd.state  = next_state;
   assign upd.accept = accept;

endmodule

>>> hdl/gated_ema_proximity_tracker.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/tready    | req_tdata: sample_mm
// rsp     | out       | rsp_tvalid/tready    | rsp_tdata: smoothed, state, accepted
// csr     | in        | csr_we               | csr_addr, csr_wdata
//
// One transaction per cycle sustained while rsp_tready stays high; each request is held
// in the input register and its result in the result register, around the single
// multiply-add and threshold compare path.
// Synchronous active-high reset clears the filter, the proximity state and the csr
// registers to their defaults.
// A stalled result holds in the output register while one more request is held in the
// input register; req_tready drops only when both are full.
module gated_ema_proximity_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gept_pkg::REQ_DW-1:0]   req_tdata,  // [11:0] sample_mm, [15:12] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [19:0] smoothed_distance, [21:20] proximity_state, [22] sample_accepted, [23] zero
   output logic [gept_pkg::RSP_DW-1:0]   rsp_tdata,
   input  logic                          csr_we,
   input  logic [gept_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [gept_pkg::CSR_DW-1:0]   csr_wdata
);
   import gept_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic [MM_W-1:0]     in_sample_ff, in_sample_in;
   logic                out_valid_ff, out_valid_in;
   logic [RSP_DW-1:0]   out_data_ff, out_data_in;
   logic [FILT_W-1:0]   filter_ff, filter_in;
   prox_state_type      state_ff, state_in;
   update_type          upd;
   logic                advance;
   logic                req_take;

   gept_update u_update (
      .sample_mm    (in_sample_ff),
      .filter_value (filter_ff),
      .state        (state_ff),
      .cfg          (cfg_ff),
      .upd          (upd)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_GATE_LOW:     cfg_in.gate_low_mm     = csr_wdata[MM_W-1:0];
            CSR_GATE_HIGH:    cfg_in.gate_high_mm    = csr_wdata[MM_W-1:0];
            CSR_RATE:         cfg_in.smoothing_rate  = csr_wdata[RATE_W-1:0];
            CSR_FREE_ABOVE:   cfg_in.free_above_mm   = csr_wdata[MM_W-1:0];
            CSR_NEAR_BELOW:   cfg_in.near_below_mm   = csr_wdata[MM_W-1:0];
            CSR_CONTACT_LOW:  cfg_in.contact_low_mm  = csr_wdata[MM_W-1:0];
            CSR_CONTACT_HIGH: cfg_in.contact_high_mm = csr_wdata[MM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      filter_in    = filter_ff;
      state_in     = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_tdata[MM_W-1:0];
      end
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      // commit the state update together with the result
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = {1'b0, upd.accept, state_code(upd.state), upd.filter};
         filter_in    = upd.filter;
         state_in     = upd.state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_low_mm     <= GATE_LOW_RST;
         cfg_ff.gate_high_mm    <= GATE_HIGH_RST;
         cfg_ff.smoothing_rate  <= RATE_RST;
         cfg_ff.free_above_mm   <= FREE_ABOVE_RST;
         cfg_ff.near_below_mm   <= NEAR_BELOW_RST;
         cfg_ff.contact_low_mm  <= CONTACT_LOW_RST;
         cfg_ff.contact_high_mm <= CONTACT_HIGH_RST;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         filter_ff              <= '0;
         state_ff               <= PROX_CLEAR;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         filter_ff    <= filter_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff <= in_sample_in;
      out_data_ff  <= out_data_in;
   end

   a_filter_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && upd.accept) |=> $stable(filter_ff))
      else $error("filter changed without an accepted sample");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid && (rsp_tdata[FILT_W-1:0] == filter_ff))
      else $error("result does not match committed filter value");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("request stalled while a stage was free");

   a_state_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_tdata[FILT_W+PSTATE_W-1:FILT_W] == state_code(state_ff)))
      else $error("reported state differs from machine state");

endmodule
